// File: src/gsp_pkg.sv
// Shared types, constants and lookup functions for the gas sensor ppm converter.
// Depends on nothing; every other file of the block imports it.
package gsp_pkg;

    localparam int ADC_BITS_DEF    = 12;
    localparam int CAL_SAMPLES_DEF = 100;

    // Shared divider: numerator and divisor widths.
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 24;

    localparam logic [23:0] SAT24      = 24'hFFFFFF;
    localparam logic [24:0] PPM_MAX_Q4 = 25'd160000;
    // Offset of 4 in Q16 that turns log2(ppm) into log2(ppm in Q14.4).
    localparam logic [25:0] EXP_BIAS   = 26'd262144;

    // Configuration register indexes.
    localparam logic [2:0] CFG_VREF = 3'd0;
    localparam logic [2:0] CFG_FS   = 3'd1;
    localparam logic [2:0] CFG_RL   = 3'd2;
    localparam logic [2:0] CFG_CAF  = 3'd3;

    localparam logic [12:0] VREF_RST = 13'd3300;
    localparam logic [12:0] FS_RST   = 13'd4096;
    localparam logic [15:0] RL_RST   = 16'd2560;
    localparam logic [15:0] CAF_RST  = 16'd2534;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_GAS = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_NO_BASE = 2'd3;

    typedef struct packed {
        logic [12:0] vref;
        logic [12:0] fs;
        logic [15:0] rl;
        logic [15:0] caf;
    } t_cfg;

    typedef struct packed {
        logic is_meas;
        logic gas_bad;
        logic gas_ch4;
    } t_item_ctl;

    // 2^(i/16) in Q16.
    function automatic logic [17:0] exp2_tab(input logic [4:0] idx);
        logic [17:0] v;
        case (idx)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // Slope 1/a in Q16 for carbon monoxide or methane.
    function automatic logic signed [18:0] coef_k1(input logic ch4);
        return ch4 ? -19'sd133747 : -19'sd97815;
    endfunction

    // Intercept -b*log2(10)/a in Q16.
    function automatic logic [19:0] coef_k0(input logic ch4);
        return ch4 ? 20'd693104 : 20'd402918;
    endfunction

endpackage

// File: src/gsp_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on gsp_pkg for the default widths.
module gsp_div import gsp_pkg::*; #(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic          r_done;

    logic [DW:0] rem_sh;
    logic        take;

    assign rem_sh = {r_rem, r_num[NW-1]};
    assign take   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NW-2:0], 1'b0};
                r_quo <= {r_quo[NW-2:0], take};
                r_rem <= take ? DW'(rem_sh - {1'b0, r_den}) : DW'(rem_sh);
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: src/gsp_front.sv
// Input side: accepts samples, classifies them and queues them for the back end.
// Depends on gsp_pkg for the item control struct.
module gsp_front import gsp_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [ADC_BITS-1:0] i_adc_sample,
    input  logic [1:0]          i_gas_select,
    input  logic                i_pop,
    output logic                o_avail,
    output t_item_ctl           o_item,
    output logic [ADC_BITS-1:0] o_adc
);

    t_item_ctl           r_ctl [2];
    logic [ADC_BITS-1:0] r_adc [2];
    logic                r_wptr;
    logic                r_rptr;
    logic [1:0]          r_cnt;

    logic push;
    logic pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_avail = r_cnt != 2'd0;
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_ctl[r_wptr] <= '{is_meas: i_action, gas_bad: i_gas_select[1],
                                   gas_ch4: i_gas_select[0]};
                r_adc[r_wptr] <= i_adc_sample;
                r_wptr        <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assign o_item = r_ctl[r_rptr];
    assign o_adc  = r_adc[r_rptr];

endmodule

// File: src/gsp_back.sv
// Back end sequencer: resistance, calibration, ratio, log2 and exp2 steps.
// Depends on gsp_pkg and instantiates the shared divider gsp_div.
module gsp_back import gsp_pkg::*; #(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_avail,
    input  t_item_ctl           i_item,
    input  logic [ADC_BITS-1:0] i_adc,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [23:0]         o_resistance_q8,
    output logic [23:0]         o_ratio_q16,
    output logic [17:0]         o_ppm_q4,
    output logic                o_calibration_done,
    output logic [1:0]          o_status
);

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int VPW   = ADC_BITS + 13;

    // Reciprocal of the calibration count: floor(x / N) = (x * M) >> (32 + L) for any
    // 32-bit x, with L = ceil(log2(N)) and M = ceil(2^(32+L) / N), which fits 33 bits.
    localparam int          REC_L    = $clog2(CAL_SAMPLES);
    localparam longint      REC_M    = ((longint'(1) << (32 + REC_L))
                                       + longint'(CAL_SAMPLES) - longint'(1))
                                       / longint'(CAL_SAMPLES);
    localparam logic [15:0] REC_M_LO = 16'(REC_M);
    localparam logic [16:0] REC_M_HI = 17'(REC_M >> 16);

    typedef enum logic [4:0] {
        S_IDLE, S_VMUL, S_VDIV, S_VWAIT, S_RMUL, S_RDIV, S_RWAIT, S_POST,
        S_AMLO, S_AMHI, S_ODIV, S_OWAIT, S_QDIV, S_QWAIT, S_LNORM, S_LSQ,
        S_KMUL, S_EADD, S_EINT, S_ESHF, S_OUT
    } t_state;

    t_state              r_state;
    t_item_ctl           r_ctl;
    logic [ADC_BITS-1:0] r_adc;
    logic [DIV_NW-1:0]   r_mul;
    logic [16:0]         r_v10;
    logic [23:0]         r_rs;
    logic [23:0]         r_ratio;
    logic [17:0]         r_ppm;
    logic                r_done;
    logic [1:0]          r_status;
    logic [31:0]         r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [23:0]         r_ro;
    logic                r_bvalid;
    logic [47:0]         r_acc;
    logic [48:0]         r_ahi;
    logic [31:0]         r_avg;
    logic [23:0]         r_lx;
    logic [4:0]          r_p;
    logic [16:0]         r_m;
    logic [15:0]         r_frac;
    logic [3:0]          r_it;
    logic signed [39:0]  r_kprod;
    logic [25:0]         r_f;
    logic [17:0]         r_em;
    logic                r_o_valid;
    logic [23:0]         r_o_rs;
    logic [23:0]         r_o_ratio;
    logic [17:0]         r_o_ppm;
    logic                r_o_done;
    logic [1:0]          r_o_status;

    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    logic                div_done;
    logic [DIV_NW-1:0]   div_quo;
    logic [23:0]         q_sat;
    logic [12:0]         fs_eff;
    logic [15:0]         caf_eff;
    logic [16:0]         vref10;
    logic [DIV_NW-1:0]   v10_eff;
    logic [VPW-1:0]      vprod;
    logic [32:0]         rprod;
    logic [32:0]         sum_ext;
    logic [31:0]         sum_new;
    logic [CNT_W-1:0]    cnt_new;
    logic [47:0]         amul_lo;
    logic [48:0]         amul_hi;
    logic [64:0]         acc_sum;
    logic [31:0]         avg_q;
    logic [33:0]         sq;
    logic signed [18:0]  k1;
    logic signed [20:0]  lval;
    logic [4:0]          lint;
    logic signed [39:0]  kprod;
    logic [17:0]         ex_lo;
    logic [17:0]         ex_hi;
    logic [17:0]         ex_diff;
    logic [24:0]         iprod;
    logic [40:0]         shv;
    logic [24:0]         vv;

    assign fs_eff  = (i_cfg.fs == '0) ? 13'd1 : i_cfg.fs;
    assign caf_eff = (i_cfg.caf == '0) ? 16'd1 : i_cfg.caf;
    assign vref10  = ({4'b0, i_cfg.vref} << 3) + ({4'b0, i_cfg.vref} << 1);
    assign q_sat   = (div_quo[DIV_NW-1:24] != '0) ? SAT24 : div_quo[23:0];
    assign v10_eff = (div_quo == '0) ? DIV_NW'(1) : div_quo;
    assign vprod   = VPW'(r_adc) * VPW'(i_cfg.vref);
    assign rprod   = 33'(vref10 - r_v10) * 33'(i_cfg.rl);
    assign sum_ext = {1'b0, r_sum} + 33'(r_rs);
    assign sum_new = sum_ext[32] ? 32'hFFFFFFFF : sum_ext[31:0];
    assign cnt_new = r_cnt + 1'b1;
    assign amul_lo = 48'(r_sum) * 48'(REC_M_LO);
    assign amul_hi = 49'(r_sum) * 49'(REC_M_HI);
    assign acc_sum = 65'(r_acc) + {r_ahi, 16'b0};
    assign avg_q   = 32'(acc_sum >> (32 + REC_L));
    assign sq      = 34'(r_m) * 34'(r_m);
    assign k1      = coef_k1(r_ctl.gas_ch4);
    assign lint    = r_p - 5'd16;
    assign lval    = {lint, r_frac};
    assign kprod   = 40'(k1) * 40'(lval);
    assign ex_lo   = exp2_tab({1'b0, r_f[15:12]});
    assign ex_hi   = exp2_tab({1'b0, r_f[15:12]} + 5'd1);
    assign ex_diff = ex_hi - ex_lo;
    assign iprod   = 25'(ex_diff[12:0]) * 25'(r_f[11:0]);
    assign shv     = (41'(r_em) << r_f[20:16]) >> 16;
    assign vv      = shv[24:0];

    assign div_start = (r_state == S_VDIV) || (r_state == S_RDIV)
                    || (r_state == S_ODIV) || (r_state == S_QDIV);

    always_comb begin
        div_num = '0;
        div_den = DIV_DW'(1);
        unique case (r_state)
            S_VDIV: begin
                div_num = (r_mul << 3) + (r_mul << 1);
                div_den = DIV_DW'(fs_eff);
            end
            S_RDIV: begin
                div_num = r_mul;
                div_den = DIV_DW'(r_v10);
            end
            S_ODIV: begin
                div_num = {r_avg, 8'b0};
                div_den = DIV_DW'(caf_eff);
            end
            S_QDIV: begin
                div_num = {r_rs, 16'b0};
                div_den = r_ro;
            end
            default: begin
                div_num = '0;
                div_den = DIV_DW'(1);
            end
        endcase
    end

    gsp_div #(
        .NW(DIV_NW),
        .DW(DIV_DW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    assign o_pop = (r_state == S_IDLE) && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_ro      <= '0;
            r_bvalid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // In S_OUT the output register is reloaded below whenever i_ready is high.
            if (i_ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_ctl    <= i_item;
                        r_adc    <= i_adc;
                        r_rs     <= '0;
                        r_ratio  <= '0;
                        r_ppm    <= '0;
                        r_done   <= 1'b0;
                        r_status <= ST_OK;
                        r_state  <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    r_mul   <= DIV_NW'(vprod);
                    r_state <= S_VDIV;
                end
                S_VDIV: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (div_done) begin
                        if (v10_eff >= DIV_NW'(vref10)) begin
                            r_state <= S_POST;
                        end else begin
                            r_v10   <= 17'(v10_eff);
                            r_state <= S_RMUL;
                        end
                    end
                end
                S_RMUL: begin
                    r_mul   <= DIV_NW'(rprod);
                    r_state <= S_RDIV;
                end
                S_RDIV: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (div_done) begin
                        r_rs    <= q_sat;
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (!r_ctl.is_meas) begin
                        r_sum <= sum_new;
                        r_cnt <= cnt_new;
                        r_state <= (cnt_new >= CNT_W'(CAL_SAMPLES)) ? S_AMLO : S_OUT;
                    end else if (r_bvalid) begin
                        r_state <= S_QDIV;
                    end else begin
                        r_status <= r_ctl.gas_bad ? ST_BAD_GAS : ST_NO_BASE;
                        r_state  <= S_OUT;
                    end
                end
                S_AMLO: begin
                    // Both partial products of the reciprocal multiply.
                    r_acc   <= amul_lo;
                    r_ahi   <= amul_hi;
                    r_state <= S_AMHI;
                end
                S_AMHI: begin
                    r_avg   <= avg_q;
                    r_state <= S_ODIV;
                end
                S_ODIV: r_state <= S_OWAIT;
                S_OWAIT: begin
                    if (div_done) begin
                        r_ro     <= (q_sat == '0) ? 24'd1 : q_sat;
                        r_bvalid <= 1'b1;
                        r_sum    <= '0;
                        r_cnt    <= '0;
                        r_done   <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_QDIV: r_state <= S_QWAIT;
                S_QWAIT: begin
                    if (div_done) begin
                        r_ratio <= q_sat;
                        if (r_ctl.gas_bad) begin
                            r_status <= ST_BAD_GAS;
                            r_state  <= S_OUT;
                        end else if (q_sat == '0) begin
                            r_status <= ST_RANGE;
                            r_state  <= S_OUT;
                        end else begin
                            r_lx    <= q_sat;
                            r_p     <= 5'd23;
                            r_state <= S_LNORM;
                        end
                    end
                end
                S_LNORM: begin
                    // Shift until the leading one reaches the top bit.
                    if (r_lx[23]) begin
                        r_m     <= r_lx[23:7];
                        r_frac  <= '0;
                        r_it    <= 4'd15;
                        r_state <= S_LSQ;
                    end else begin
                        r_lx <= {r_lx[22:0], 1'b0};
                        r_p  <= r_p - 5'd1;
                    end
                end
                S_LSQ: begin
                    // One fraction bit of log2 per squaring.
                    if (sq[33]) begin
                        r_m          <= sq[33:17];
                        r_frac[r_it] <= 1'b1;
                    end else begin
                        r_m <= sq[32:16];
                    end
                    r_it <= r_it - 4'd1;
                    if (r_it == 4'd0) begin
                        r_state <= S_KMUL;
                    end
                end
                S_KMUL: begin
                    r_kprod <= kprod;
                    r_state <= S_EADD;
                end
                S_EADD: begin
                    r_f     <= 26'(r_kprod >>> 16) + 26'(coef_k0(r_ctl.gas_ch4)) + EXP_BIAS;
                    r_state <= S_EINT;
                end
                S_EINT: begin
                    // A negative exponent leaves ppm zero with status ok.
                    if (r_f[25]) begin
                        r_state <= S_OUT;
                    end else if (r_f[24:16] >= 9'd24) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_OUT;
                    end else begin
                        r_em    <= ex_lo + 18'(iprod >> 12);
                        r_state <= S_ESHF;
                    end
                end
                S_ESHF: begin
                    if (vv > PPM_MAX_Q4) begin
                        r_status <= ST_RANGE;
                    end else begin
                        r_ppm <= vv[17:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_rs     <= r_rs;
                        r_o_ratio  <= r_ratio;
                        r_o_ppm    <= r_ppm;
                        r_o_done   <= r_done;
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_o_valid;
    assign o_resistance_q8    = r_o_rs;
    assign o_ratio_q16        = r_o_ratio;
    assign o_ppm_q4           = r_o_ppm;
    assign o_calibration_done = r_o_done;
    assign o_status           = r_o_status;

endmodule

// File: src/gas_sensor_ppm_converter.sv
// Top level of the gas sensor ppm converter: configuration registers,
// input queue (gsp_front) and arithmetic sequencer (gsp_back). Uses gsp_pkg.
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  --------------------------------
//  sample    in         i_valid / o_ready          i_action, i_adc_sample, i_gas_select
//  result    out        o_valid / i_ready          o_resistance_q8, o_ratio_q16,
//                                                  o_ppm_q4, o_calibration_done, o_status
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Every sample passes through one shared restoring divider; each division holds the
// sequencer until the divider is done, so the divider sets the rate. A calibration
// sample needs up to two divisions (one when the reading is at or above Vref), plus a
// reciprocal multiply in S_AMLO and S_AMHI for the baseline average over the
// calibration set and a third division when it completes the baseline; a measurement
// needs up to three divisions, up to 23 normalize shifts, 16 squaring steps, exp2 steps.
// The front queue holds two samples, so o_ready stays high while the back end works on
// one sample and a result waits in the output register, until two more samples queue.
// Reset is synchronous and active low; it restores the configuration defaults and
// clears the baseline and the running sum.
// The configuration port is always ready; writes to indexes past the last register
// are ignored.
module gas_sensor_ppm_converter import gsp_pkg::*; #(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter int ADC_BITS    = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [ADC_BITS-1:0] i_adc_sample,
    input  logic [1:0]          i_gas_select,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [23:0]         o_resistance_q8,
    output logic [23:0]         o_ratio_q16,
    output logic [17:0]         o_ppm_q4,
    output logic                o_calibration_done,
    output logic [1:0]          o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    t_cfg r_cfg;

    logic                pop;
    logic                avail;
    t_item_ctl           item;
    logic [ADC_BITS-1:0] item_adc;

    assign o_cfg_ready = 1'b1;

    // Config registers. The user must write only while the block is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vref <= VREF_RST;
            r_cfg.fs   <= FS_RST;
            r_cfg.rl   <= RL_RST;
            r_cfg.caf  <= CAF_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VREF: r_cfg.vref <= i_cfg_data[12:0];
                CFG_FS:   r_cfg.fs   <= i_cfg_data[12:0];
                CFG_RL:   r_cfg.rl   <= i_cfg_data;
                CFG_CAF:  r_cfg.caf  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front end classifies each sample transaction and queues it.
    gsp_front #(
        .ADC_BITS(ADC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_adc_sample(i_adc_sample),
        .i_gas_select(i_gas_select),
        .i_pop       (pop),
        .o_avail     (avail),
        .o_item      (item),
        .o_adc       (item_adc)
    );

    // The back end converts one queued sample at a time into a result transaction.
    gsp_back #(
        .ADC_BITS   (ADC_BITS),
        .CAL_SAMPLES(CAL_SAMPLES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_avail           (avail),
        .i_item            (item),
        .i_adc             (item_adc),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_resistance_q8   (o_resistance_q8),
        .o_ratio_q16       (o_ratio_q16),
        .o_ppm_q4          (o_ppm_q4),
        .o_calibration_done(o_calibration_done),
        .o_status          (o_status)
    );

endmodule
